FILE: rtl/asejf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asejf_pkg
// Shared widths, register indexes, reset values and control bundles for the
// ADC moving average / exponential average jitter filter.
// ----------------------------------------------------------------------------
package asejf_pkg;

    localparam int SAMPLE_BITS    = 12;
    localparam int FINE_BITS      = SAMPLE_BITS + 8;
    localparam int LEN_W          = 5;
    localparam int ALPHA_W        = 8;
    localparam int STATS_W        = 8;
    localparam int CFG_W          = 8;
    localparam int CFG_IDX_W      = 2;
    localparam int RAW_SUM_W      = 20;
    localparam int EMA_SUM_W      = 28;
    localparam int MAX_WINDOW_DEF = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SMA_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EMA_ALPHA    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STATS_WINDOW = 2'd2;

    localparam logic [LEN_W-1:0]   SMA_LENGTH_RST   = 5'd10;
    localparam logic [ALPHA_W-1:0] EMA_ALPHA_RST    = 8'd51;
    localparam logic [STATS_W-1:0] STATS_WINDOW_RST = 8'd40;

    typedef struct packed {
        logic clear;
        logic rd_en;
        logic upd;
    } ring_ctrl_t;

    typedef struct packed {
        logic mult_en;
        logic add_en;
    } ema_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/adc_sma_ema_jitter_filter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adc_sma_ema_jitter_filter_unit
// ADC sample filter: moving average over a ring memory, exponential average
// in Q12.8 and windowed jitter sums of raw, average and exponential values.
//
//   channel   signals                          direction  word
//   sample    sample_valid/sample_stall        in         sample
//   result    result_valid/result_stall        out        averages, jitter sums
//   config    cfg_we/cfg_index/cfg_data        in         register write
//
// a sample passes the ring update, the exponential product and sum, and the
// bit-serial divider for the moving average before its word is loaded; the next
// sample can enter only once that word is loaded, so one sample at a time
// after reset the registers hold 10 / 51 / 40 and all state is zero; no sweep
// a finished word waits in the output register while the next sample enters
// ----------------------------------------------------------------------------
module adc_sma_ema_jitter_filter_unit #(
    parameter int MAX_WINDOW = asejf_pkg::MAX_WINDOW_DEF
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                sample_valid,
    output logic                               sample_stall,
    input  wire [asejf_pkg::SAMPLE_BITS-1:0]   sample,
    output logic                               result_valid,
    input  wire                                result_stall,
    output logic [asejf_pkg::SAMPLE_BITS-1:0]  sma_value,
    output logic [asejf_pkg::SAMPLE_BITS-1:0]  ema_rounded,
    output logic [asejf_pkg::FINE_BITS-1:0]    ema_fine,
    output logic                               stats_valid,
    output logic [asejf_pkg::RAW_SUM_W-1:0]    raw_jitter_sum,
    output logic [asejf_pkg::RAW_SUM_W-1:0]    sma_jitter_sum,
    output logic [asejf_pkg::EMA_SUM_W-1:0]    ema_jitter_sum,
    input  wire                                cfg_we,
    input  wire [asejf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [asejf_pkg::CFG_W-1:0]         cfg_data
);
    import asejf_pkg::*;

    localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW + 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_LOAD  = 5'b00010,
        ST_START = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [LEN_W-1:0]       sma_length_reg;
    logic [ALPHA_W-1:0]     alpha_reg;
    logic [STATS_W-1:0]     stats_window_reg;
    logic [LEN_W-1:0]       eff_len;

    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [SAMPLE_BITS-1:0] prev_raw_reg;
    logic [SAMPLE_BITS-1:0] prev_sma_reg;
    logic [FINE_BITS-1:0]   prev_ema_reg;
    logic                   have_prev_reg;
    logic [RAW_SUM_W-1:0]   raw_acc_reg, raw_acc_next;
    logic [RAW_SUM_W-1:0]   sma_acc_reg, sma_acc_next;
    logic [EMA_SUM_W-1:0]   ema_acc_reg, ema_acc_next;
    logic [STATS_W-1:0]     count_reg, count_next;
    logic                   report;

    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] sma_out_reg;
    logic [SAMPLE_BITS-1:0] ema_rnd_reg;
    logic [FINE_BITS-1:0]   ema_fine_reg;
    logic                   stats_valid_reg;
    logic [RAW_SUM_W-1:0]   raw_sum_reg;
    logic [RAW_SUM_W-1:0]   sma_sum_reg;
    logic [EMA_SUM_W-1:0]   ema_sum_reg;

    logic                   in_accept;
    logic                   out_take;
    logic                   out_load;
    logic                   len_write;

    ring_ctrl_t             ring_ctrl;
    ema_ctrl_t              ema_ctrl;
    logic [SUM_W-1:0]       ring_sum;
    logic [LEN_W-1:0]       ring_fill;
    logic                   div_done;
    logic [SAMPLE_BITS-1:0] sma_q;
    logic [FINE_BITS-1:0]   ema_cur;
    logic [FINE_BITS:0]     ema_round_sum;

    logic [SAMPLE_BITS-1:0] raw_delta;
    logic [SAMPLE_BITS-1:0] sma_delta;
    logic [FINE_BITS-1:0]   ema_delta;

    // config registers
    assign len_write = cfg_we && (cfg_index == REG_SMA_LENGTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sma_length_reg   <= SMA_LENGTH_RST;
            alpha_reg        <= EMA_ALPHA_RST;
            stats_window_reg <= STATS_WINDOW_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SMA_LENGTH:   sma_length_reg   <= cfg_data[LEN_W-1:0];
                REG_EMA_ALPHA:    alpha_reg        <= cfg_data[ALPHA_W-1:0];
                REG_STATS_WINDOW: stats_window_reg <= cfg_data[STATS_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        priority if (sma_length_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (32'(sma_length_reg) > MAX_WINDOW)
        begin
            eff_len = LEN_W'(MAX_WINDOW);
        end
        else
        begin
            eff_len = sma_length_reg;
        end
    end

    // sequencer
    assign in_accept = sample_valid && !sample_stall;
    assign out_take  = out_valid_reg && !result_stall;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || !result_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (sample_valid) state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_START;
            ST_START: state_next = ST_DIV;
            ST_DIV:   if (div_done) state_next = ST_DONE;
            ST_DONE:  if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign sample_stall = (state_reg != ST_IDLE);

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sample_reg <= sample;
        end
    end

    assign ring_ctrl.clear = len_write;
    assign ring_ctrl.rd_en = in_accept;
    assign ring_ctrl.upd   = (state_reg == ST_LOAD);

    assign ema_ctrl.mult_en = (state_reg == ST_LOAD);
    assign ema_ctrl.add_en  = (state_reg == ST_START);

    asejf_ring #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_ring (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ring_ctrl),
        .len    (eff_len),
        .sample (sample_reg),
        .sum    (ring_sum),
        .fill   (ring_fill)
    );

    asejf_div #(
        .SUM_W (SUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_START),
        .dividend (ring_sum),
        .divisor  (ring_fill),
        .done     (div_done),
        .quotient (sma_q)
    );

    asejf_ema u_ema (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ema_ctrl),
        .alpha    (alpha_reg),
        .sample   (sample_reg),
        .ema_fine (ema_cur)
    );

    // jitter sums
    always_comb
    begin
        raw_delta = (sample_reg >= prev_raw_reg) ? sample_reg - prev_raw_reg
                                                 : prev_raw_reg - sample_reg;
        sma_delta = (sma_q >= prev_sma_reg) ? sma_q - prev_sma_reg
                                            : prev_sma_reg - sma_q;
        ema_delta = (ema_cur >= prev_ema_reg) ? ema_cur - prev_ema_reg
                                              : prev_ema_reg - ema_cur;
        if (have_prev_reg)
        begin
            raw_acc_next = raw_acc_reg + RAW_SUM_W'(raw_delta);
            sma_acc_next = sma_acc_reg + RAW_SUM_W'(sma_delta);
            ema_acc_next = ema_acc_reg + EMA_SUM_W'(ema_delta);
            count_next   = count_reg + 1'b1;
        end
        else
        begin
            raw_acc_next = raw_acc_reg;
            sma_acc_next = sma_acc_reg;
            ema_acc_next = ema_acc_reg;
            count_next   = count_reg;
        end
        report        = (count_next >= stats_window_reg);
        ema_round_sum = {1'b0, ema_cur} + (FINE_BITS + 1)'(128);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_raw_reg  <= '0;
            prev_sma_reg  <= '0;
            prev_ema_reg  <= '0;
            have_prev_reg <= 1'b0;
            raw_acc_reg   <= '0;
            sma_acc_reg   <= '0;
            ema_acc_reg   <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                prev_raw_reg  <= sample_reg;
                prev_sma_reg  <= sma_q;
                prev_ema_reg  <= ema_cur;
                have_prev_reg <= 1'b1;
                raw_acc_reg   <= report ? '0 : raw_acc_next;
                sma_acc_reg   <= report ? '0 : sma_acc_next;
                ema_acc_reg   <= report ? '0 : ema_acc_next;
                count_reg     <= report ? '0 : count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output word
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            sma_out_reg     <= sma_q;
            ema_rnd_reg     <= ema_round_sum[FINE_BITS-1:8];
            ema_fine_reg    <= ema_cur;
            stats_valid_reg <= report;
            raw_sum_reg     <= report ? raw_acc_next : '0;
            sma_sum_reg     <= report ? sma_acc_next : '0;
            ema_sum_reg     <= report ? ema_acc_next : '0;
        end
    end

    assign result_valid   = out_valid_reg;
    assign sma_value      = sma_out_reg;
    assign ema_rounded    = ema_rnd_reg;
    assign ema_fine       = ema_fine_reg;
    assign stats_valid    = stats_valid_reg;
    assign raw_jitter_sum = raw_sum_reg;
    assign sma_jitter_sum = sma_sum_reg;
    assign ema_jitter_sum = ema_sum_reg;

endmodule

`default_nettype wire

FILE: rtl/asejf_ring.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asejf_ring
// Sample ring memory with running sum, write position and fill count.
// Entries past the fill count read as zero, so a restart needs no sweep.
// ----------------------------------------------------------------------------
module asejf_ring #(
    parameter int MAX_WINDOW = asejf_pkg::MAX_WINDOW_DEF
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire asejf_pkg::ring_ctrl_t         ctrl,
    input  wire [asejf_pkg::LEN_W-1:0]         len,
    input  wire [asejf_pkg::SAMPLE_BITS-1:0]   sample,
    output logic [asejf_pkg::SAMPLE_BITS+$clog2(MAX_WINDOW+1)-1:0] sum,
    output logic [asejf_pkg::LEN_W-1:0]        fill
);
    import asejf_pkg::*;

    localparam int IDX_W = $clog2(MAX_WINDOW);
    localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW + 1);

    logic [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic [IDX_W-1:0]       pos_reg, pos_next;
    logic [LEN_W-1:0]       fill_reg, fill_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [SAMPLE_BITS-1:0] old_word;

    // memory port: read at accept, write back on update
    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[pos_reg];
        end
        if (ctrl.upd)
        begin
            mem[pos_reg] <= sample;
        end
    end

    always_comb
    begin
        old_word  = (fill_reg >= len) ? rd_data_reg : '0;
        sum_next  = sum_reg - SUM_W'(old_word) + SUM_W'(sample);
        fill_next = (fill_reg < len) ? fill_reg + 1'b1 : fill_reg;
        if ((32'(pos_reg) + 32'd1) >= 32'(len))
        begin
            pos_next = '0;
        end
        else
        begin
            pos_next = pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            fill_reg <= '0;
            sum_reg  <= '0;
        end
        else if (ctrl.clear)
        begin
            pos_reg  <= '0;
            fill_reg <= '0;
            sum_reg  <= '0;
        end
        else if (ctrl.upd)
        begin
            pos_reg  <= pos_next;
            fill_reg <= fill_next;
            sum_reg  <= sum_next;
        end
    end

    assign sum  = sum_reg;
    assign fill = fill_reg;

endmodule

`default_nettype wire

FILE: rtl/asejf_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asejf_div
// Restoring bit-serial divider, one quotient bit per cycle, for the
// moving average (window sum over fill count).
// ----------------------------------------------------------------------------
module asejf_div #(
    parameter int SUM_W = asejf_pkg::SAMPLE_BITS + 5
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               start,
    input  wire [SUM_W-1:0]                   dividend,
    input  wire [asejf_pkg::LEN_W-1:0]        divisor,
    output logic                              done,
    output logic [asejf_pkg::SAMPLE_BITS-1:0] quotient
);
    import asejf_pkg::*;

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0] quo_reg, quo_next;
    logic [LEN_W-1:0] rem_reg, rem_next;
    logic [LEN_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [LEN_W:0]   trial;
    logic [LEN_W:0]   diff;

    always_comb
    begin
        trial = {rem_reg, quo_reg[SUM_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        if (trial >= {1'b0, dvs_reg})
        begin
            rem_next = diff[LEN_W-1:0];
            quo_next = {quo_reg[SUM_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[LEN_W-1:0];
            quo_next = {quo_reg[SUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(SUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg[SAMPLE_BITS-1:0];

endmodule

`default_nettype wire

FILE: rtl/asejf_ema.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asejf_ema
// Exponential average in unsigned Q12.8: seeded by the first sample, then
// ema += (alpha * (sample*256 - ema)) >>> 8, with the product registered.
// ----------------------------------------------------------------------------
module asejf_ema (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire asejf_pkg::ema_ctrl_t        ctrl,
    input  wire [asejf_pkg::ALPHA_W-1:0]     alpha,
    input  wire [asejf_pkg::SAMPLE_BITS-1:0] sample,
    output logic [asejf_pkg::FINE_BITS-1:0]  ema_fine
);
    import asejf_pkg::*;

    localparam int DIFF_W = FINE_BITS + 1;
    localparam int PROD_W = ALPHA_W + 1 + DIFF_W;
    localparam int STEP_W = PROD_W - 8;

    logic [FINE_BITS-1:0]     ema_reg;
    logic                     seeded_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [DIFF_W-1:0] diff;
    logic signed [ALPHA_W:0]  alpha_s;
    logic signed [STEP_W-1:0] step;
    logic signed [STEP_W-1:0] ema_sum;

    always_comb
    begin
        diff    = $signed({1'b0, sample, 8'd0}) - $signed({1'b0, ema_reg});
        alpha_s = $signed({1'b0, alpha});
        step    = prod_reg[PROD_W-1:8];
        ema_sum = $signed(STEP_W'(ema_reg)) + step;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mult_en)
        begin
            prod_reg <= alpha_s * diff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ema_reg    <= '0;
            seeded_reg <= 1'b0;
        end
        else if (ctrl.add_en)
        begin
            seeded_reg <= 1'b1;
            if (seeded_reg)
            begin
                ema_reg <= ema_sum[FINE_BITS-1:0];
            end
            else
            begin
                ema_reg <= {sample, 8'd0};
            end
        end
    end

    assign ema_fine = ema_reg;

endmodule

`default_nettype wire

FILE: tb/adc_sma_ema_jitter_filter_unit_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adc_sma_ema_jitter_filter_unit_checker
// Watches the sample, result and register-write ports of the filter. It keeps
// its own copy of the averaging, exponential and jitter state, works out the
// word each accepted sample must produce, and compares every accepted result
// word field by field against the oldest word still outstanding.
// ----------------------------------------------------------------------------
module adc_sma_ema_jitter_filter_unit_checker
    import asejf_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    sample_valid,
    input  wire                    sample_stall,
    input  wire [SAMPLE_BITS-1:0]  sample,
    input  wire                    result_valid,
    input  wire                    result_stall,
    input  wire [SAMPLE_BITS-1:0]  sma_value,
    input  wire [SAMPLE_BITS-1:0]  ema_rounded,
    input  wire [FINE_BITS-1:0]    ema_fine,
    input  wire                    stats_valid,
    input  wire [RAW_SUM_W-1:0]    raw_jitter_sum,
    input  wire [RAW_SUM_W-1:0]    sma_jitter_sum,
    input  wire [EMA_SUM_W-1:0]    ema_jitter_sum,
    input  wire                    cfg_we,
    input  wire [CFG_IDX_W-1:0]    cfg_index,
    input  wire [CFG_W-1:0]        cfg_data,
    output int                     fail_count,
    output int                     pending
);

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sma;
        logic [SAMPLE_BITS-1:0] ema_round;
        logic [FINE_BITS-1:0]   ema_q8;
        logic                   report;
        logic [RAW_SUM_W-1:0]   raw_sum;
        logic [RAW_SUM_W-1:0]   avg_sum;
        logic [EMA_SUM_W-1:0]   exp_sum;
    } filter_word_t;

    // register copies
    logic [LEN_W-1:0]       win_length;
    logic [ALPHA_W-1:0]     alpha;
    logic [STATS_W-1:0]     report_len;

    // averaging and jitter state
    logic [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
    logic [15:0]            win_sum;
    int unsigned            ring_pos;
    int unsigned            fill;
    logic [FINE_BITS-1:0]   ema_q;
    logic                   seeded;
    logic [SAMPLE_BITS-1:0] last_raw;
    logic [SAMPLE_BITS-1:0] last_avg;
    logic [FINE_BITS-1:0]   last_ema;
    logic                   have_last;
    logic [RAW_SUM_W-1:0]   raw_acc;
    logic [RAW_SUM_W-1:0]   avg_acc;
    logic [EMA_SUM_W-1:0]   ema_acc;
    logic [7:0]             delta_cnt;

    filter_word_t           expected_words[$];
    filter_word_t           next_word;
    filter_word_t           oldest;

    function automatic logic [31:0] distance(input logic [31:0] a, input logic [31:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    task automatic clear_window();
        foreach (ring[i])
            ring[i] = '0;
        win_sum  = '0;
        ring_pos = 0;
        fill     = 0;
    endtask

    task automatic clear_filter();
        win_length = SMA_LENGTH_RST;
        alpha      = EMA_ALPHA_RST;
        report_len = STATS_WINDOW_RST;
        clear_window();
        ema_q      = '0;
        seeded     = 1'b0;
        last_raw   = '0;
        last_avg   = '0;
        last_ema   = '0;
        have_last  = 1'b0;
        raw_acc    = '0;
        avg_acc    = '0;
        ema_acc    = '0;
        delta_cnt  = '0;
    endtask

    task automatic load_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        case (idx)
            REG_SMA_LENGTH:
            begin
                win_length = data[LEN_W-1:0];
                clear_window();
            end
            REG_EMA_ALPHA:    alpha      = data[ALPHA_W-1:0];
            REG_STATS_WINDOW: report_len = data[STATS_W-1:0];
            default:          ;
        endcase
    endtask

    task automatic filter_step(input logic [SAMPLE_BITS-1:0] s, output filter_word_t w);
        int unsigned            len;
        int unsigned            at;
        int                     diff;
        int                     prod;
        int                     step;
        logic [SAMPLE_BITS-1:0] avg;

        // moving average over the ring
        if (win_length == 0)
            len = 1;
        else if (win_length > MAX_WINDOW)
            len = MAX_WINDOW;
        else
            len = win_length;
        at       = ring_pos % len;
        win_sum  = win_sum - ring[at] + s;
        ring[at] = s;
        ring_pos = (at + 1 >= len) ? 0 : at + 1;
        if (fill < len)
            fill++;
        avg = win_sum / fill;

        // exponential average in Q12.8, floor on the scaled step
        if (!seeded)
        begin
            ema_q  = {s, 8'h00};
            seeded = 1'b1;
        end
        else
        begin
            diff  = int'({s, 8'h00}) - int'(ema_q);
            prod  = int'(alpha) * diff;
            step  = prod >>> 8;
            ema_q = ema_q + step[FINE_BITS-1:0];
        end

        if (have_last)
        begin
            raw_acc   = raw_acc + distance(s, last_raw);
            avg_acc   = avg_acc + distance(avg, last_avg);
            ema_acc   = ema_acc + distance(ema_q, last_ema);
            delta_cnt = delta_cnt + 1'b1;
        end
        last_raw  = s;
        last_avg  = avg;
        last_ema  = ema_q;
        have_last = 1'b1;

        w.sma       = avg;
        w.ema_round = (ema_q + 21'd128) >> 8;
        w.ema_q8    = ema_q;
        w.report    = (delta_cnt >= report_len);
        if (w.report)
        begin
            w.raw_sum = raw_acc;
            w.avg_sum = avg_acc;
            w.exp_sum = ema_acc;
            raw_acc   = '0;
            avg_acc   = '0;
            ema_acc   = '0;
            delta_cnt = '0;
        end
        else
        begin
            w.raw_sum = '0;
            w.avg_sum = '0;
            w.exp_sum = '0;
        end
    endtask

    task automatic compare_field(input string name, input longint unsigned want,
                                 input longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_filter();
            expected_words.delete();
            fail_count = 0;
            pending   <= 0;
        end
        else
        begin
            if (cfg_we)
                load_register(cfg_index, cfg_data);
            if (result_valid && !result_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("result word with no sample outstanding");
                    fail_count++;
                end
                else
                begin
                    oldest = expected_words.pop_front();
                    compare_field("sma_value", oldest.sma, sma_value);
                    compare_field("ema_rounded", oldest.ema_round, ema_rounded);
                    compare_field("ema_fine", oldest.ema_q8, ema_fine);
                    compare_field("stats_valid", oldest.report, stats_valid);
                    compare_field("raw_jitter_sum", oldest.raw_sum, raw_jitter_sum);
                    compare_field("sma_jitter_sum", oldest.avg_sum, sma_jitter_sum);
                    compare_field("ema_jitter_sum", oldest.exp_sum, ema_jitter_sum);
                end
            end
            if (sample_valid && !sample_stall)
            begin
                filter_step(sample, next_word);
                expected_words.push_back(next_word);
            end
            pending <= expected_words.size();
        end
    end

endmodule

`default_nettype wire

FILE: tb/adc_sma_ema_jitter_filter_unit_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adc_sma_ema_jitter_filter_unit_test
// Drives converter samples into the filter with random gaps and random result
// back-pressure, rewrites the window, weight and report registers between
// bursts, and lets the checker beside the block judge every result word.
// ----------------------------------------------------------------------------
module adc_sma_ema_jitter_filter_unit_test;
    import asejf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 30;
    localparam int HANG_LIMIT    = 3000;
    localparam int RANDOM_ITEMS  = 700;

    logic                   clk;
    logic                   rst_n        = 1'b0;
    logic                   sample_valid = 1'b0;
    logic [SAMPLE_BITS-1:0] sample       = '0;
    logic                   result_stall = 1'b0;
    logic                   cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index    = REG_SMA_LENGTH;
    logic [CFG_W-1:0]       cfg_data     = '0;

    wire                    sample_stall;
    wire                    result_valid;
    wire [SAMPLE_BITS-1:0]  sma_value;
    wire [SAMPLE_BITS-1:0]  ema_rounded;
    wire [FINE_BITS-1:0]    ema_fine;
    wire                    stats_valid;
    wire [RAW_SUM_W-1:0]    raw_jitter_sum;
    wire [RAW_SUM_W-1:0]    sma_jitter_sum;
    wire [EMA_SUM_W-1:0]    ema_jitter_sum;

    int                     fail_count;
    int                     pending;
    int                     hang_count   = 0;
    logic                   gaps_on      = 1'b1;
    int                     signal_level = 2048;

    adc_sma_ema_jitter_filter_unit u_top (.*);

    adc_sma_ema_jitter_filter_unit_checker u_checker (.*);

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
        result_stall <= gaps_on && ($urandom_range(99) < 7);

    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
            hang_count <= 0;
        else
            hang_count <= hang_count + 1;
        if (hang_count >= HANG_LIMIT)
        begin
            $display("adc_sma_ema_jitter_filter_unit_test NOT OK");
            $finish;
        end
    end

    task automatic push_sample(input logic [SAMPLE_BITS-1:0] value);
        while (gaps_on && $urandom_range(99) < 7)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= value;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
    endtask

    // wait until every outstanding word is back and the block has gone quiet
    task automatic settle();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // mix of rail values, full-range noise and a drifting level with small jitter
    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        int v;
        case ($urandom_range(9))
            0:       v = 0;
            1:       v = 4095;
            2, 3, 4: v = $urandom_range(4095);
            default:
            begin
                if ($urandom_range(19) == 0)
                    signal_level = $urandom_range(4095);
                v = signal_level + $urandom_range(16) - 8;
                if (v < 0)
                    v = 0;
                if (v > 4095)
                    v = 4095;
            end
        endcase
        return v[SAMPLE_BITS-1:0];
    endfunction

    function automatic logic [CFG_W-1:0] pick_length();
        case ($urandom_range(5))
            0:       return 8'd1;
            1:       return 8'd16;
            2:       return 8'd0;
            3:       return 8'($urandom_range(17, 255));
            default: return 8'($urandom_range(1, 16));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_alpha();
        case ($urandom_range(5))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_report_len();
        case ($urandom_range(5))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd255;
            default: return 8'($urandom_range(2, 30));
        endcase
    endfunction

    initial
    begin
        int sent;
        int phase;
        int burst;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, rail to rail, first sample seeds the average
        push_sample(12'd0);
        push_sample(12'd4095);
        push_sample(12'd4095);
        push_sample(12'd0);

        // length zero acts as one, weight zero holds, report every word
        settle();
        write_reg(REG_SMA_LENGTH, 8'd0);
        write_reg(REG_EMA_ALPHA, 8'd0);
        write_reg(REG_STATS_WINDOW, 8'd0);
        push_sample(12'd4095);
        push_sample(12'd0);
        push_sample(12'd2048);

        // oversized length clamps, full weight, report after each delta
        settle();
        write_reg(REG_SMA_LENGTH, 8'd31);
        write_reg(REG_EMA_ALPHA, 8'd255);
        write_reg(REG_STATS_WINDOW, 8'd1);
        push_sample(12'd4095);
        push_sample(12'd4095);
        push_sample(12'd1);

        // unused index ignored, upper length bits dropped
        settle();
        write_reg(REG_UNUSED, 8'hFF);
        write_reg(REG_SMA_LENGTH, 8'hE3);
        write_reg(REG_EMA_ALPHA, 8'd1);
        write_reg(REG_STATS_WINDOW, 8'd200);
        repeat (4) push_sample(pick_sample());

        // report window lowered below the running count
        settle();
        write_reg(REG_STATS_WINDOW, 8'd3);
        push_sample(12'hA5A);
        push_sample(12'h5A5);

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            settle();
            gaps_on <= (phase != 4);
            if ($urandom_range(2) != 0)
                write_reg(REG_SMA_LENGTH, pick_length());
            if ($urandom_range(2) != 0)
                write_reg(REG_EMA_ALPHA, pick_alpha());
            if ($urandom_range(2) != 0)
                write_reg(REG_STATS_WINDOW, pick_report_len());
            if ($urandom_range(9) == 0)
                write_reg(REG_UNUSED, 8'($urandom_range(255)));
            burst = (phase == 4) ? 80 : $urandom_range(10, 60);
            repeat (burst) push_sample(pick_sample());
            sent  += burst;
            phase++;
        end

        gaps_on <= 1'b1;
        settle();
        if (fail_count == 0 && pending == 0)
            $display("adc_sma_ema_jitter_filter_unit_test OK");
        else
            $display("adc_sma_ema_jitter_filter_unit_test NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
